@@ rtl/phd_pkg.sv @@
// shared types and constants for the packet header deframer
package phd_pkg;

    localparam int HDR_BYTES = 12;
    localparam logic [3:0] HDR_LAST = 4'(HDR_BYTES - 1);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_SHORT_HDR   = 3'd1;
    localparam t_status ST_BAD_MAGIC   = 3'd2;
    localparam t_status ST_BAD_VERSION = 3'd3;
    localparam t_status ST_TOO_LONG    = 3'd4;
    localparam t_status ST_TRUNCATED   = 3'd5;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MAGIC   = 2'd0;
    localparam t_cfg_idx CFG_VERSION = 2'd1;
    localparam t_cfg_idx CFG_MAX_LEN = 2'd2;

    localparam logic KIND_BODY   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef logic [1:0] t_count;

    typedef struct packed {
        logic        kind;
        logic [7:0]  body_byte;
        t_status     status;
        logic [15:0] command;
        logic [31:0] body_length;
        logic        last;
    } t_result;

endpackage

@@ rtl/phd_if.sv @@
// valid/ready channel interfaces for the packet header deframer
interface phd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface phd_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  body_byte;
    logic [2:0]  status;
    logic [15:0] command;
    logic [31:0] body_length;
    logic        last;

    modport source (output valid, output kind, output body_byte, output status,
                    output command, output body_length, output last, input ready);
    modport sink (input valid, input kind, input body_byte, input status,
                  input command, input body_length, input last, output ready);
endinterface

interface phd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/phd_fifo.sv @@
// three-entry result queue taking up to two results per cycle
module phd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  phd_pkg::t_count  i_push,
    input  phd_pkg::t_result i_wr0,
    input  phd_pkg::t_result i_wr1,
    input  logic             i_pop,
    output phd_pkg::t_result o_head,
    output logic             o_valid,
    output logic             o_room
);
    import phd_pkg::*;

    t_result r_mem [3];
    t_result n_mem [3];
    t_count  r_cnt;
    t_count  n_cnt;
    t_count  base;

    always_comb begin
        n_mem = r_mem;
        base  = r_cnt;
        if (i_pop) begin
            n_mem[0] = r_mem[1];
            n_mem[1] = r_mem[2];
            base     = r_cnt - 2'd1;
        end
        if (i_push != 2'd0) begin
            n_mem[base] = i_wr0;
        end
        if (i_push == 2'd2) begin
            n_mem[base + 2'd1] = i_wr1;
        end
        n_cnt = base + i_push;
    end

    always_ff @(posedge i_clk) begin
        r_mem <= n_mem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_head  = r_mem[0];
    assign o_valid = (r_cnt != 2'd0);
    assign o_room  = (r_cnt <= 2'd1);

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push != 2'd0) |-> (r_cnt <= 2'd1))
        else $error("result pushed without room");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != 2'd0))
        else $error("pop from empty result queue");

    a_push_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push == 2'd2 && !i_pop) |=> (r_cnt == $past(r_cnt) + 2'd2))
        else $error("double push lost an entry");

endmodule

@@ rtl/packet_header_deframer.sv @@
// top level: 12-byte header parser, checker and body forwarder
// Takes one buffer byte per cycle and updates the header/body state in the same cycle;
// each transfer in yields zero, one or two results, which go into a three-entry result
// queue read one per cycle. Input is taken whenever the queue has room for two results,
// so with the output ready the block runs at one byte per cycle, and only a byte that
// ends a frame with a body byte plus a status item holds back the next input byte.
module packet_header_deframer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    phd_cfg_if.sink   i_cfg,
    phd_in_if.sink    i_in,
    phd_out_if.source o_out
);
    import phd_pkg::*;

    logic [31:0] r_exp_magic;
    logic [7:0]  r_exp_version;
    logic [31:0] r_max_len;

    logic [1:0]  r_phase,     n_phase;
    logic [3:0]  r_hdr_idx,   n_hdr_idx;
    logic [31:0] r_magic,     n_magic;
    logic [7:0]  r_version,   n_version;
    logic [15:0] r_command,   n_command;
    logic [31:0] r_length,    n_length;
    logic [31:0] r_remaining, n_remaining;

    logic        in_fire;
    logic        eob;
    logic [7:0]  b;
    logic [31:0] len_full;
    t_status     hdr_status;
    t_result     res0;
    t_result     res1;
    t_count      n_push;
    t_result     head;
    logic        q_valid;
    logic        q_room;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_magic   <= '0;
            r_exp_version <= '0;
            r_max_len     <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_MAGIC:   r_exp_magic   <= i_cfg.data;
                CFG_VERSION: r_exp_version <= i_cfg.data[7:0];
                CFG_MAX_LEN: r_max_len     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign in_fire  = i_in.valid && i_in.ready;
    assign eob      = i_in.end_of_buffer;
    assign b        = i_in.data_byte;
    assign len_full = {b, r_length[23:0]};

    always_comb begin
        if (r_magic != r_exp_magic) begin
            hdr_status = ST_BAD_MAGIC;
        end else if (r_version != r_exp_version) begin
            hdr_status = ST_BAD_VERSION;
        end else if (len_full > r_max_len) begin
            hdr_status = ST_TOO_LONG;
        end else if (len_full == 32'd0) begin
            hdr_status = ST_OK;
        end else begin
            hdr_status = ST_TRUNCATED;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_hdr_idx   = r_hdr_idx;
        n_magic     = r_magic;
        n_version   = r_version;
        n_command   = r_command;
        n_length    = r_length;
        n_remaining = r_remaining;
        res0        = '0;
        res1        = '0;
        n_push      = 2'd0;

        if (in_fire) begin
            unique case (r_phase)
                PH_SKIP: begin
                    if (eob) begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_BODY: begin
                    n_remaining     = r_remaining - 32'd1;
                    res0.kind       = KIND_BODY;
                    res0.body_byte  = b;
                    res1.kind       = KIND_STATUS;
                    res1.command    = r_command;
                    res1.body_length = r_length;
                    res1.last       = 1'b1;
                    if (n_remaining == 32'd0) begin
                        res0.last   = 1'b1;
                        res1.status = ST_OK;
                        n_push      = 2'd2;
                        n_phase     = eob ? PH_HEADER : PH_SKIP;
                    end else if (eob) begin
                        res1.status = ST_TRUNCATED;
                        n_push      = 2'd2;
                        n_phase     = PH_HEADER;
                        n_remaining = 32'd0;
                    end else begin
                        n_push = 2'd1;
                    end
                end
                PH_HEADER: begin
                    case (r_hdr_idx)
                        4'd0:  n_magic[7:0]    = b;
                        4'd1:  n_magic[15:8]   = b;
                        4'd2:  n_magic[23:16]  = b;
                        4'd3:  n_magic[31:24]  = b;
                        4'd4:  n_version       = b;
                        4'd5:  n_command[7:0]  = b;
                        4'd6:  n_command[15:8] = b;
                        4'd8:  n_length[7:0]   = b;
                        4'd9:  n_length[15:8]  = b;
                        4'd10: n_length[23:16] = b;
                        4'd11: n_length[31:24] = b;
                        default: ;
                    endcase
                    if (r_hdr_idx != HDR_LAST) begin
                        n_hdr_idx = r_hdr_idx + 4'd1;
                        if (eob) begin
                            res0.kind   = KIND_STATUS;
                            res0.status = ST_SHORT_HDR;
                            res0.last   = 1'b1;
                            n_push      = 2'd1;
                            n_hdr_idx   = 4'd0;
                        end
                    end else begin
                        n_hdr_idx = 4'd0;
                        if (hdr_status == ST_TRUNCATED && !eob) begin
                            n_phase     = PH_BODY;
                            n_remaining = len_full;
                        end else begin
                            res0.kind        = KIND_STATUS;
                            res0.status      = hdr_status;
                            res0.command     = r_command;
                            res0.body_length = len_full;
                            res0.last        = 1'b1;
                            n_push           = 2'd1;
                            n_phase          = eob ? PH_HEADER : PH_SKIP;
                        end
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_idx   <= 4'd0;
            r_remaining <= 32'd0;
        end else begin
            r_phase     <= n_phase;
            r_hdr_idx   <= n_hdr_idx;
            r_remaining <= n_remaining;
        end
    end

    always_ff @(posedge i_clk) begin
        r_magic   <= n_magic;
        r_version <= n_version;
        r_command <= n_command;
        r_length  <= n_length;
    end

    phd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (n_push),
        .i_wr0   (res0),
        .i_wr1   (res1),
        .i_pop   (q_valid && o_out.ready),
        .o_head  (head),
        .o_valid (q_valid),
        .o_room  (q_room)
    );

    assign i_in.ready        = q_room;
    assign o_out.valid       = q_valid;
    assign o_out.kind        = head.kind;
    assign o_out.body_byte   = head.body_byte;
    assign o_out.status      = head.status;
    assign o_out.command     = head.command;
    assign o_out.body_length = head.body_length;
    assign o_out.last        = head.last;

    a_body_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_remaining != 32'd0))
        else $error("body phase with nothing remaining");

    a_hdr_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_idx <= HDR_LAST)
        else $error("header index past header end");

    a_skip_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_phase == PH_SKIP) |-> (n_push == 2'd0))
        else $error("result produced while skipping");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == KIND_STATUS) |-> o_out.last)
        else $error("status item without last");

endmodule
